FILE: rtl/ipv4_prefix_match_list_defines.svh
// Assertion macros shared by the IPv4 prefix match list RTL.
// Depends on nothing; included by the top level only.
`ifndef IPV4_PREFIX_MATCH_LIST_DEFINES_SVH
`define IPV4_PREFIX_MATCH_LIST_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define IPML_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define IPML_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/ipml_pkg.sv
// Package for the IPv4 prefix match list: sizes, command codes, the structs
// passed along the cell chain, and the prefix mask function. No dependencies.
package ipml_pkg;

    localparam int MAX_RULES   = 16;
    localparam int IDX_W       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W       = $clog2(MAX_RULES + 1);
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 6;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD   = 2'd0;
    localparam t_cmd CMD_CHECK = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;

    // A lookup moving down the chain, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] addr;
        logic              hit;
    } t_probe;

    // Rule write broadcast to all cells; the addressed cell stores it.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } t_wr;

    // Leading-ones mask. Lengths above 32 shift everything out, which gives
    // the full mask, so saturation comes for free.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

FILE: rtl/ipml_cell.sv
// One cell of the rule chain: holds one rule and compares the passing lookup.
// Depends on ipml_pkg.
module ipml_cell
    import ipml_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr              i_wr,
    input  t_probe           i_probe,
    output t_probe           o_probe
);

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_mask;
    t_probe            r_probe;
    t_probe            n_probe;
    logic              w_live;
    logic              w_match;

    // Only rules below the fill count take part in a lookup.
    assign w_live  = CNT_W'(i_index) < i_count;
    assign w_match = w_live && (((i_probe.addr ^ r_addr) & r_mask) == '0);

    always_comb begin
        n_probe     = i_probe;
        n_probe.hit = i_probe.hit | (i_probe.active & w_match);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_addr <= i_wr.addr;
            r_mask <= i_wr.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.active <= 1'b0;
        end else begin
            r_probe.active <= n_probe.active;
        end
        r_probe.addr <= n_probe.addr;
        r_probe.hit  <= n_probe.hit;
    end

    assign o_probe = r_probe;

endmodule

FILE: rtl/ipv4_prefix_match_list.sv
// Top level of the IPv4 prefix match list: command decode, fill count,
// result register and the chain of rule cells. Depends on ipml_pkg,
// ipml_cell and ipv4_prefix_match_list_defines.svh.
//
// Usage: one input channel (i_valid / o_ready) carries a command, an address
// and a prefix length; one output channel (o_valid / i_ready) returns one
// transaction per command with the matched flag and the status flag.
// Add appends a rule to the next free cell, or reports status 1 when all
// MAX_RULES cells are taken. Clear resets the fill count. Check sends the
// address down the row of rule cells, one cell per cycle; each cell ORs in
// its own prefix compare, and the result passes the holding stage and
// the output register. Add, clear and the unused command code answer
// through the holding stage and the output register. The block works on
// one command at a time: o_ready returns high in the cycle after the result
// is loaded into the output register, so no new command is taken before the
// last one is through, a check waiting on the whole cell chain. A stalled
// receiver holds the output register; a finished result then waits in a
// holding stage and no new command is taken until it moves on. Reset empties
// the list and the output channel.
`include "ipv4_prefix_match_list_defines.svh"

module ipv4_prefix_match_list
    import ipml_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [PLEN_W-1:0] i_prefix_len,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_matched,
    output logic              o_status
);

    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    logic             r_done;
    logic             r_res_matched;
    logic             r_res_status;
    logic             r_out_valid;
    logic             r_out_matched;
    logic             r_out_status;

    logic             w_accept;
    logic             w_full;
    logic             w_chain_done;
    logic             w_load_out;
    t_wr              w_wr;
    t_probe           w_probe [MAX_RULES+1];

    assign o_ready  = !r_busy;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(MAX_RULES));

    // A successful add writes the rule into the cell at the fill count.
    always_comb begin
        w_wr.en   = w_accept && (i_command == CMD_ADD) && !w_full;
        w_wr.idx  = r_count[IDX_W-1:0];
        w_wr.addr = i_address;
        w_wr.mask = prefix_mask(i_prefix_len);
    end

    // A check enters the first cell in the cycle it is accepted.
    always_comb begin
        w_probe[0].active = w_accept && (i_command == CMD_CHECK);
        w_probe[0].addr   = i_address;
        w_probe[0].hit    = 1'b0;
    end

    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        ipml_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_count (r_count),
            .i_wr    (w_wr),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

    assign w_chain_done = w_probe[MAX_RULES].active;
    assign w_load_out   = r_done && (!r_out_valid || i_ready);

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            unique case (i_command)
                CMD_ADD: begin
                    if (!w_full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                CMD_CLEAR: begin
                    r_count <= '0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Command tracking and the holding stage in front of the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load_out) begin
                r_busy <= 1'b0;
            end
            if (w_accept && (i_command != CMD_CHECK)) begin
                r_done <= 1'b1;
            end else if (w_chain_done) begin
                r_done <= 1'b1;
            end else if (w_load_out) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_command != CMD_CHECK)) begin
            r_res_matched <= 1'b0;
            r_res_status  <= (i_command == CMD_ADD) && w_full;
        end else if (w_chain_done) begin
            r_res_matched <= w_probe[MAX_RULES].hit;
            r_res_status  <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_matched <= r_res_matched;
            r_out_status  <= r_res_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;
    assign o_status  = r_out_status;

    // The fill count never passes the number of cells.
    `IPML_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_RULES))
    // A lookup leaves the chain only while its command is outstanding.
    `IPML_ASSERT_SAME(a_chain_owned, i_clk, i_rst_n, w_chain_done, r_busy && !r_done)
    // A finished result always belongs to an outstanding command.
    `IPML_ASSERT_SAME(a_done_busy, i_clk, i_rst_n, r_done, r_busy)
    // An add that fits grows the list by exactly one rule.
    `IPML_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, w_wr.en, r_count == $past(r_count) + CNT_W'(1))

endmodule
